// ----- design/sga_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the softened gravity accumulator.
// Used by softened_gravity_accumulator; depends on nothing.
package sga_pkg;

  localparam int PosW  = 32;   // Q8.24 position
  localparam int DiffW = 34;   // signed separation
  localparam int MagW  = 34;   // separation magnitude
  localparam int QW    = 46;   // |r|^2 + eps^2, Q.24
  localparam int RootW = 32;   // |r| in Q.21
  localparam int DenW  = 78;   // q * s
  localparam int NumW  = 79;   // |d| << 45
  localparam int RemW  = 80;
  localparam int QuoW  = 50;
  localparam int SumW  = 48;
  localparam int MulW  = 34;
  localparam int QHalf = 23;   // q split for the two partial products
  localparam int CntW  = 7;

  localparam logic [CntW-1:0] SqrtSteps = 7'd31;
  localparam logic [CntW-1:0] DivSteps  = 7'd78;

  typedef struct packed {
    logic                   first_pair;
    logic                   last_pair;
    logic                   sink_valid;
    logic signed [PosW-1:0] sink_x;
    logic signed [PosW-1:0] sink_y;
    logic signed [PosW-1:0] sink_z;
    logic signed [PosW-1:0] src_x;
    logic signed [PosW-1:0] src_y;
    logic signed [PosW-1:0] src_z;
    logic signed [PosW-1:0] y_shift;
  } in_beat_t;

  typedef struct packed {
    logic signed [SumW-1:0] acc_x;
    logic signed [SumW-1:0] acc_y;
    logic signed [SumW-1:0] acc_z;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } state_t;

endpackage

// ----- design/softened_gravity_accumulator.sv -----
`timescale 1ns / 1ps
// Plummer-softened gravity accumulator: one sink/source pair per beat.
// Depends on sga_pkg. Single module around one shared multiplier and divider.
//
//   channel | direction | handshake      | payload
//   in_     | input     | valid / stall  | in_beat_t
//   out_    | output    | valid / stall  | out_beat_t
//   cfg_    | input     | valid / ready  | softening_sq, 32 bit
//
// A pair is processed in full before the next is accepted: idle, squaring, root, multiply,
// then divide and accumulate per axis, and finish; the bit-serial divider dominates.
// A pair whose squared distance plus softening is zero skips root, multiply and division.
// Reset (synchronous, active low) clears sums, softening and control state.
// A result waits in the output register; the next pair is taken meanwhile
// and only its own emission waits for the output to free up.
module softened_gravity_accumulator
  import sga_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PosW-1:0]   cfg_data
);

  localparam logic signed [SumW+1:0] SumMax = {3'b000, {(SumW-1){1'b1}}};
  localparam logic signed [SumW+1:0] SumMin = {3'b111, {(SumW-1){1'b0}}};
  localparam logic [QuoW-1:0]        TermCap = QuoW'(1) << SumW;

  state_t                 state_r, state_nxt;
  logic [1:0]             axis_r, axis_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic [PosW-1:0]        soft_r;
  logic [MagW-1:0]        mag_r [3];
  logic [2:0]             neg_r;
  logic                   emit_r;
  logic [QW-1:0]          q_r, q_nxt;
  logic [63:0]            srem_r, srem_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [DenW-1:0]        den_r, den_nxt;
  logic [NumW-1:0]        num_r, num_nxt;
  logic [RemW-1:0]        rem_r, rem_nxt;
  logic [QuoW-1:0]        quo_r, quo_nxt;
  logic                   ovf_r, ovf_nxt;
  logic signed [SumW-1:0] sum_r [3];
  logic                   out_valid_r;
  out_beat_t              out_data_r;

  logic                   accept;
  logic signed [DiffW-1:0] dx, dy, dz;
  logic [MulW-1:0]        mul_a, mul_b;
  logic [2*MulW-1:0]      prod;
  logic [RemW-1:0]        rem_sh;
  logic                   rem_ge;
  logic [63:0]            sq_try;
  logic [QuoW-1:0]        term;
  logic signed [SumW+1:0] sum_new;
  logic signed [SumW-1:0] sum_sat;
  logic                   out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign cfg_ready = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign dx = DiffW'(in_data.src_x) - DiffW'(in_data.sink_x);
  assign dy = DiffW'(in_data.src_y) - DiffW'(in_data.sink_y) + DiffW'(in_data.y_shift);
  assign dz = DiffW'(in_data.src_z) - DiffW'(in_data.sink_z);

  // Shared multiplier: squares, then the two partial products of q * s.
  always_comb begin
    mul_a = mag_r[axis_r];
    mul_b = mag_r[axis_r];
    if (state_r == ST_MUL) begin
      mul_b = MulW'(sres_r[RootW-1:0]);
      mul_a = (cnt_r == '0) ? MulW'(q_r[QHalf-1:0]) : MulW'(q_r[QW-1:QHalf]);
    end
  end
  assign prod = mul_a * mul_b;

  assign rem_sh = {rem_r[RemW-2:0], num_r[NumW-1]};
  assign rem_ge = rem_sh >= RemW'(den_r);
  assign sq_try = sres_r + sbit_r;

  assign term    = (ovf_r || quo_r > TermCap) ? TermCap : quo_r;
  assign sum_new = neg_r[axis_r] ? (SumW+2)'(sum_r[axis_r]) + (SumW+2)'(term)
                                 : (SumW+2)'(sum_r[axis_r]) - (SumW+2)'(term);
  always_comb begin
    if (sum_new > SumMax)      sum_sat = SumMax[SumW-1:0];
    else if (sum_new < SumMin) sum_sat = SumMin[SumW-1:0];
    else                       sum_sat = sum_new[SumW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    srem_nxt  = srem_r;
    sres_nxt  = sres_r;
    sbit_nxt  = sbit_r;
    den_nxt   = den_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          q_nxt     = QW'(soft_r);
          axis_nxt  = '0;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        q_nxt = q_r + QW'(prod[2*MulW-1:24]);
        if (axis_r == 2'd2) begin
          axis_nxt  = '0;
          cnt_nxt   = '0;
          srem_nxt  = {q_nxt[QW-1:0], 18'd0};
          sres_nxt  = '0;
          sbit_nxt  = 64'd1 << 62;
          // zero distance without softening adds nothing
          state_nxt = (q_nxt == '0) ? ST_FIN : ST_SQRT;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      ST_SQRT: begin
        if (srem_r >= sq_try) begin
          srem_nxt = srem_r - sq_try;
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        if (cnt_r == SqrtSteps) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL: begin
        if (cnt_r == '0) begin
          den_nxt = DenW'(prod);
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          den_nxt   = den_r + (DenW'(prod) << QHalf);
          cnt_nxt   = '0;
          num_nxt   = {mag_r[0], 45'd0};
          rem_nxt   = '0;
          quo_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_sh - RemW'(den_r) : rem_sh;
        quo_nxt = {quo_r[QuoW-2:0], rem_ge};
        ovf_nxt = ovf_r | quo_r[QuoW-1];
        num_nxt = num_r << 1;
        if (cnt_r == DivSteps) begin
          cnt_nxt   = '0;
          state_nxt = ST_ACC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ACC: begin
        if (axis_r == 2'd2) begin
          state_nxt = ST_FIN;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          num_nxt   = {mag_r[axis_r + 2'd1], 45'd0};
          rem_nxt   = '0;
          quo_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_FIN: begin
        // hold until the output register frees up
        if (!emit_r || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= '0;
      cnt_r       <= '0;
      soft_r      <= '0;
      out_valid_r <= 1'b0;
      emit_r      <= 1'b0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) soft_r <= cfg_data;
      if (state_r == ST_FIN && emit_r && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (accept) begin
        emit_r <= in_data.last_pair && in_data.sink_valid;
        if (in_data.first_pair) begin
          sum_r[0] <= '0;
          sum_r[1] <= '0;
          sum_r[2] <= '0;
        end
      end
      if (state_r == ST_ACC) sum_r[axis_r] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    srem_r <= srem_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    den_r  <= den_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    ovf_r  <= ovf_nxt;
    if (accept) begin
      mag_r[0] <= dx[DiffW-1] ? MagW'(-dx) : MagW'(dx);
      mag_r[1] <= dy[DiffW-1] ? MagW'(-dy) : MagW'(dy);
      mag_r[2] <= dz[DiffW-1] ? MagW'(-dz) : MagW'(dz);
      neg_r    <= {dz[DiffW-1], dy[DiffW-1], dx[DiffW-1]};
    end
    if (state_r == ST_FIN && emit_r && out_free) begin
      out_data_r.acc_x <= sum_r[0];
      out_data_r.acc_y <= sum_r[1];
      out_data_r.acc_z <= sum_r[2];
    end
  end

endmodule
